FILE: sv/sdtq_pkg.sv
`timescale 1ns / 1ps
package sdtq_pkg;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_STARTED  = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  localparam logic [30:0] WINDOW_RESET = 31'd210000;
  // Most timers that one tick may fire, and the counter width that holds it.
  localparam int          MAX_RESULTS  = 16;
  localparam int          FIRE_W       = 5;

  typedef struct packed {
    logic        operation;
    logic [7:0]  task_id;
    logic [31:0] event_word;
    logic [19:0] timeout;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_task;
    logic [31:0] fired_event;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REMOVE,
    ST_PLACE,
    ST_FIRE
  } state_e;

  typedef struct packed {
    logic load;
    logic idx_inc;
    logic idx_clr;
    logic remove;
    logic insert;
    logic emit_key;
    logic reject;
    logic fire_take;
    logic fire_flush;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic match;
    logic place_hit;
    logic full;
    logic head_due;
    logic fire_max;
  } stat_t;

endpackage

FILE: sv/sdtq_ctrl.sv
`timescale 1ns / 1ps
module sdtq_ctrl import sdtq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  op_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (op_i == OP_TICK) ? ST_FIRE : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        priority if (stat_i.at_end) begin
          if (stat_i.full) begin
            cmd_o.emit_key = 1'b1;
            cmd_o.reject   = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_PLACE;
          end
        end else if (stat_i.match) begin
          state_d = ST_REMOVE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_REMOVE: begin
        cmd_o.remove  = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = ST_PLACE;
      end
      ST_PLACE: begin
        if (stat_i.at_end || stat_i.place_hit) begin
          cmd_o.insert   = 1'b1;
          cmd_o.emit_key = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_FIRE: begin
        if (stat_i.head_due && !stat_i.fire_max) begin
          cmd_o.fire_take = 1'b1;
        end else begin
          cmd_o.fire_flush = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/sdtq_datapath.sv
`timescale 1ns / 1ps
module sdtq_datapath import sdtq_pkg::*; #(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_word_t    in_word_i,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output out_word_t   result_o,
  output logic        result_valid_o
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  logic [7:0]  task_q [MAX_TIMERS];
  logic [31:0] ev_q   [MAX_TIMERS];
  logic [31:0] dl_q   [MAX_TIMERS];

  logic [CW-1:0]     count_q, idx_q;
  logic [31:0]       tick_q;
  logic [30:0]       win_q;
  logic [7:0]        cur_task_q;
  logic [31:0]       cur_ev_q, cur_dl_q;
  logic [FIRE_W-1:0] fire_n_q;
  logic              pend_v_q;
  logic [7:0]        pend_task_q;
  logic [31:0]       pend_ev_q;
  logic              out_v_q;
  out_word_t         out_q;

  logic [IW-1:0] pos;
  logic [31:0]   diff, head_diff;

  assign pos       = idx_q[IW-1:0];
  assign diff      = dl_q[pos] - cur_dl_q;
  assign head_diff = tick_q - dl_q[0];

  always_comb begin
    stat_o.at_end    = (idx_q == count_q);
    stat_o.match     = !stat_o.at_end && (task_q[pos] == cur_task_q) && (ev_q[pos] == cur_ev_q);
    stat_o.place_hit = !stat_o.at_end && (diff != 32'd0) && (diff < {1'b0, win_q});
    stat_o.full      = (count_q == CW'(MAX_TIMERS));
    stat_o.head_due  = (count_q != '0) && (head_diff < {1'b0, win_q});
    stat_o.fire_max  = (fire_n_q == FIRE_W'(MAX_RESULTS));
  end

  // Table rows only ever move by one place, so each row reads its neighbors.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (cmd_i.remove || cmd_i.fire_take) begin
        if ((CW'(i) >= idx_q) && (i + 1 < MAX_TIMERS)) begin
          task_q[i] <= task_q[(i + 1) % MAX_TIMERS];
          ev_q[i]   <= ev_q[(i + 1) % MAX_TIMERS];
          dl_q[i]   <= dl_q[(i + 1) % MAX_TIMERS];
        end
      end else if (cmd_i.insert) begin
        if (CW'(i) == idx_q) begin
          task_q[i] <= cur_task_q;
          ev_q[i]   <= cur_ev_q;
          dl_q[i]   <= cur_dl_q;
        end else if ((CW'(i) > idx_q) && (i > 0)) begin
          task_q[i] <= task_q[(i + MAX_TIMERS - 1) % MAX_TIMERS];
          ev_q[i]   <= ev_q[(i + MAX_TIMERS - 1) % MAX_TIMERS];
          dl_q[i]   <= dl_q[(i + MAX_TIMERS - 1) % MAX_TIMERS];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_task_q <= in_word_i.task_id;
      cur_ev_q   <= in_word_i.event_word;
      cur_dl_q   <= tick_q + {12'd0, in_word_i.timeout};
    end
    if (cmd_i.fire_take) begin
      pend_task_q <= task_q[0];
      pend_ev_q   <= ev_q[0];
    end
    if (cmd_i.emit_key) begin
      out_q.kind        <= cmd_i.reject ? KIND_REJECTED : KIND_STARTED;
      out_q.fired_task  <= cur_task_q;
      out_q.fired_event <= cur_ev_q;
      out_q.last        <= 1'b1;
    end else if (cmd_i.fire_take || cmd_i.fire_flush) begin
      out_q.kind        <= KIND_FIRED;
      out_q.fired_task  <= pend_task_q;
      out_q.fired_event <= pend_ev_q;
      out_q.last        <= cmd_i.fire_flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      tick_q   <= '0;
      win_q    <= WINDOW_RESET;
      fire_n_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q    <= '0;
        fire_n_q <= '0;
        if (in_word_i.operation == OP_TICK) begin
          tick_q <= tick_q + 32'd1;
        end
      end else if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.remove || cmd_i.fire_take) begin
        count_q <= count_q - CW'(1);
      end else if (cmd_i.insert) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.fire_take) begin
        fire_n_q <= fire_n_q + FIRE_W'(1);
        pend_v_q <= 1'b1;
      end else if (cmd_i.fire_flush) begin
        pend_v_q <= 1'b0;
      end
      out_v_q <= cmd_i.emit_key || ((cmd_i.fire_take || cmd_i.fire_flush) && pend_v_q);
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_v_q;

endmodule

FILE: sv/sorted_deadline_timer_queue_unit.sv
`timescale 1ns / 1ps
// Sorted deadline timer queue. A word is taken when start_i is high and busy_o
// is low. A start word scans the table for its key one entry per cycle, takes
// a found entry out in the REMOVE state, then scans again for the deadline
// place, and always yields one result word. A tick word takes due timers
// from the head of the table and yields one word per fired timer (at most
// sixteen), the final one marked by last; a tick with nothing due yields none.
// Results appear on result_o for exactly one cycle with result_valid_o high
// and cannot be held off, so the receiver must take every strobed word. The
// final result of a word shows in the first cycle in which busy_o is low
// again, and a new word may be taken in that same cycle. The due window
// register is written with cfg_we_i and must only change while the block is
// idle.
module sorted_deadline_timer_queue_unit import sdtq_pkg::*; #(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  in_word_t    in_word_i,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  output out_word_t   result_o,
  output logic        result_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences the scans; the datapath holds the sorted table.
  sdtq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (in_word_i.operation),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  sdtq_datapath #(
    .MAX_TIMERS(MAX_TIMERS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_word_i     (in_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  // A result only follows work that was in progress.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // A taken word always puts the block to work in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not start work");

  // Start answers are single words and so always carry last.
  a_start_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.kind != KIND_FIRED)) |-> result_o.last)
    else $error("start answer without last");

endmodule
